### rtl/pfcs_pkg.sv
package pfcs_pkg;

    localparam int ADDRESS_BITS = 18;
    localparam int BLOCK_COUNT  = 5;

    localparam int ADDR_W       = 18;
    localparam int DATA_W       = 8;
    localparam int BLK_W        = 3;
    localparam int MAP_W        = 5;
    localparam int STEP_W       = 3;
    localparam int KNOWN_BLOCKS = 5;

    localparam int VALID_BLOCKS = (BLOCK_COUNT < KNOWN_BLOCKS) ? BLOCK_COUNT : KNOWN_BLOCKS;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                              : ADDR_W'((1 << ADDRESS_BITS) - 1);
    localparam logic [MAP_W-1:0]  ALL_BLOCKS  = MAP_W'((1 << VALID_BLOCKS) - 1);
    localparam logic [BLK_W:0]    BLOCK_LIMIT = (BLK_W + 1)'(VALID_BLOCKS);

    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = ADDR_W'(32'h5555);
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = ADDR_W'(32'h2AAA);
    localparam logic [DATA_W-1:0] UNLOCK_DATA_A = 8'hAA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA_B = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
    localparam logic [DATA_W-1:0] CMD_CHIP      = 8'h10;
    localparam logic [DATA_W-1:0] CMD_BLOCK     = 8'h30;

    localparam logic [STEP_W-1:0] PROGRAM_STEPS = 3'd4;
    localparam logic [STEP_W-1:0] ERASE_STEPS   = 3'd6;
    localparam logic [STEP_W-1:0] STEP_DATA     = 3'd3;

    typedef enum logic [1:0] {
        OP_PROGRAM     = 2'd0,
        OP_ERASE_CHIP  = 2'd1,
        OP_ERASE_BLOCK = 2'd2,
        OP_RESPONSE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ACCESS   = 2'd1,
        ERR_MISMATCH = 2'd2,
        ERR_BLOCK    = 2'd3
    } err_t;

    typedef struct packed {
        op_t               func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [BLK_W-1:0]  block_index;
        logic              big_endian_bytes;
        logic              big_endian_bits;
        logic              access_failed;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] bus_data;
        logic              use_big_endian_bytes;
        logic              use_big_endian_bits;
        logic              success;
        err_t              error_code;
        logic [DATA_W-1:0] read_back;
        logic [MAP_W-1:0]  erased_map;
    } result_t;

    function automatic logic [ADDR_W-1:0] block_base(input logic [BLK_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        case (idx)
            3'd1:    base = ADDR_W'(32'h0000_4000);
            3'd2:    base = ADDR_W'(32'h0000_6000);
            3'd3:    base = ADDR_W'(32'h0000_8000);
            3'd4:    base = ADDR_W'(32'h0002_0000);
            default: base = '0;
        endcase
        return base;
    endfunction

    // first known block whose masked base matches
    function automatic logic [MAP_W-1:0] block_hit(input logic [ADDR_W-1:0] taddr);
        logic [MAP_W-1:0] hit;
        hit = '0;
        for (int i = KNOWN_BLOCKS - 1; i >= 0; i--) begin
            if ((block_base(BLK_W'(i)) & ADDR_MASK) == taddr) begin
                hit = MAP_W'(1 << i);
            end
        end
        return hit;
    endfunction

endpackage

### rtl/parallel_flash_command_sequencer_core.sv
// a request is registered at its input stage and any result that it produces leaves
// from the result register
// throughput: one request per cycle while the result register is not stalled
// reset: asynchronous, active low; clears the sequencer state, the erased map and
// both valid flags
module parallel_flash_command_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [1:0]                   func,
    input  logic [pfcs_pkg::ADDR_W-1:0]  address,
    input  logic [pfcs_pkg::DATA_W-1:0]  data,
    input  logic [pfcs_pkg::BLK_W-1:0]   block_index,
    input  logic                         big_endian_bytes,
    input  logic                         big_endian_bits,
    input  logic                         access_failed,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [1:0]                   kind,
    output logic [pfcs_pkg::ADDR_W-1:0]  bus_address,
    output logic [pfcs_pkg::DATA_W-1:0]  bus_data,
    output logic                         use_big_endian_bytes,
    output logic                         use_big_endian_bits,
    output logic                         success,
    output logic [1:0]                   error_code,
    output logic [pfcs_pkg::DATA_W-1:0]  read_back,
    output logic [pfcs_pkg::MAP_W-1:0]   erased_map
);
    import pfcs_pkg::*;

    logic               item_vld_reg;
    item_t              item_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic               busy_reg,     busy_next;
    op_t                op_reg,       op_next;
    logic [STEP_W-1:0]  step_reg,     step_next;
    logic               polling_reg,  polling_next;
    logic [ADDR_W-1:0]  taddr_reg,    taddr_next;
    logic [DATA_W-1:0]  tdata_reg,    tdata_next;
    logic [1:0]         flags_reg,    flags_next;
    logic [MAP_W-1:0]   erased_reg,   erased_next;

    logic               advance;
    logic               emit;
    logic               finish;
    logic [STEP_W-1:0]  step_inc;
    result_t            res_next;

    function automatic result_t write_req(input op_t op, input logic [STEP_W-1:0] stp,
                                          input logic [ADDR_W-1:0] taddr,
                                          input logic [DATA_W-1:0] tdata,
                                          input logic [1:0] flags);
        result_t r;
        r = '0;
        r.kind = KIND_WRITE;
        if (op == OP_PROGRAM) begin
            case (stp)
                3'd0:
                begin
                    r.bus_address = UNLOCK_ADDR_A;
                    r.bus_data    = UNLOCK_DATA_A;
                end
                3'd1:
                begin
                    r.bus_address = UNLOCK_ADDR_B;
                    r.bus_data    = UNLOCK_DATA_B;
                end
                STEP_DATA:
                begin
                    r.bus_address          = taddr;
                    r.bus_data             = tdata;
                    r.use_big_endian_bytes = flags[1];
                    r.use_big_endian_bits  = flags[0];
                end
                default:
                begin
                    r.bus_address = UNLOCK_ADDR_A;
                    r.bus_data    = CMD_PROGRAM;
                end
            endcase
        end
        else
        begin
            case (stp)
                3'd0:
                begin
                    r.bus_address = UNLOCK_ADDR_A;
                    r.bus_data    = UNLOCK_DATA_A;
                end
                3'd1:
                begin
                    r.bus_address = UNLOCK_ADDR_B;
                    r.bus_data    = UNLOCK_DATA_B;
                end
                3'd2:
                begin
                    r.bus_address = UNLOCK_ADDR_A;
                    r.bus_data    = CMD_ERASE;
                end
                3'd3:
                begin
                    r.bus_address = UNLOCK_ADDR_A;
                    r.bus_data    = UNLOCK_DATA_A;
                end
                3'd4:
                begin
                    r.bus_address = UNLOCK_ADDR_B;
                    r.bus_data    = UNLOCK_DATA_B;
                end
                default:
                begin
                    if (op == OP_ERASE_CHIP) begin
                        r.bus_address = UNLOCK_ADDR_A;
                        r.bus_data    = CMD_CHIP;
                    end
                    else
                    begin
                        r.bus_address = taddr;
                        r.bus_data    = CMD_BLOCK;
                    end
                end
            endcase
        end
        r.bus_address = r.bus_address & ADDR_MASK;
        return r;
    endfunction

    function automatic result_t read_req(input op_t op, input logic [ADDR_W-1:0] taddr,
                                         input logic [1:0] flags);
        result_t r;
        r = '0;
        r.kind        = KIND_READ;
        r.bus_address = taddr;
        if (op == OP_PROGRAM) begin
            r.use_big_endian_bytes = flags[1];
            r.use_big_endian_bits  = flags[0];
        end
        return r;
    endfunction

    function automatic result_t done_res(input logic ok, input err_t err,
                                         input logic [DATA_W-1:0] rb);
        result_t r;
        r = '0;
        r.kind       = KIND_DONE;
        r.success    = ok;
        r.error_code = err;
        r.read_back  = rb;
        return r;
    endfunction

    assign advance   = item_vld_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = item_vld_reg && !advance;
    assign step_inc  = step_reg + 3'd1;

    always_comb
    begin
        busy_next    = busy_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        polling_next = polling_reg;
        taddr_next   = taddr_reg;
        tdata_next   = tdata_reg;
        flags_next   = flags_reg;
        erased_next  = erased_reg;
        emit         = 1'b0;
        finish       = 1'b0;
        res_next     = '0;

        if (item_reg.func != OP_RESPONSE) begin
            if (!busy_reg) begin
                emit         = 1'b1;
                busy_next    = 1'b1;
                op_next      = item_reg.func;
                step_next    = '0;
                polling_next = 1'b0;
                flags_next   = '0;
                tdata_next   = '0;
                unique case (item_reg.func)
                    OP_PROGRAM:
                    begin
                        taddr_next = item_reg.address & ADDR_MASK;
                        tdata_next = item_reg.data;
                        flags_next = {item_reg.big_endian_bytes, item_reg.big_endian_bits};
                    end
                    OP_ERASE_CHIP:
                    begin
                        taddr_next = '0;
                    end
                    default:
                    begin
                        if ({1'b0, item_reg.block_index} >= BLOCK_LIMIT) begin
                            taddr_next = '0;
                            finish     = 1'b1;
                            res_next   = done_res(1'b0, ERR_BLOCK, '0);
                        end
                        else
                        begin
                            taddr_next = block_base(item_reg.block_index) & ADDR_MASK;
                        end
                    end
                endcase
                if (!finish) begin
                    res_next = write_req(op_next, '0, taddr_next, tdata_next, flags_next);
                end
            end
        end
        else if (busy_reg) begin
            emit = 1'b1;
            if (!polling_reg) begin
                if (item_reg.access_failed) begin
                    finish   = 1'b1;
                    res_next = done_res(1'b0, ERR_ACCESS, '0);
                end
                else
                begin
                    step_next = step_inc;
                    if (step_inc >= ((op_reg == OP_PROGRAM) ? PROGRAM_STEPS : ERASE_STEPS)) begin
                        polling_next = 1'b1;
                        res_next     = read_req(op_reg, taddr_reg, flags_reg);
                    end
                    else
                    begin
                        res_next = write_req(op_reg, step_inc, taddr_reg, tdata_reg, flags_reg);
                    end
                end
            end
            else if (item_reg.access_failed) begin
                // a chip erase marks everything even when its poll fails
                if (op_reg == OP_ERASE_CHIP) begin
                    erased_next = ALL_BLOCKS;
                end
                finish   = 1'b1;
                res_next = done_res(1'b0, ERR_ACCESS, '0);
            end
            else
            begin
                unique case (op_reg)
                    OP_PROGRAM:
                    begin
                        if (item_reg.data[7] != tdata_reg[7]) begin
                            res_next = read_req(op_reg, taddr_reg, flags_reg);
                        end
                        else if (item_reg.data != tdata_reg) begin
                            finish   = 1'b1;
                            res_next = done_res(1'b0, ERR_MISMATCH, item_reg.data);
                        end
                        else
                        begin
                            finish   = 1'b1;
                            res_next = done_res(1'b1, ERR_NONE, '0);
                        end
                    end
                    OP_ERASE_CHIP:
                    begin
                        if (item_reg.data[7]) begin
                            erased_next = ALL_BLOCKS;
                            finish      = 1'b1;
                            res_next    = done_res(1'b1, ERR_NONE, '0);
                        end
                        else
                        begin
                            res_next = read_req(op_reg, taddr_reg, flags_reg);
                        end
                    end
                    default:
                    begin
                        if (item_reg.data[7]) begin
                            erased_next = erased_reg | block_hit(taddr_reg);
                            finish      = 1'b1;
                            res_next    = done_res(1'b1, ERR_NONE, '0);
                        end
                        else
                        begin
                            res_next = read_req(op_reg, taddr_reg, flags_reg);
                        end
                    end
                endcase
            end
        end

        if (finish) begin
            busy_next    = 1'b0;
            polling_next = 1'b0;
            step_next    = '0;
        end
        res_next.erased_map = erased_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_vld_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            op_reg        <= OP_PROGRAM;
            step_reg      <= '0;
            polling_reg   <= 1'b0;
            taddr_reg     <= '0;
            tdata_reg     <= '0;
            flags_reg     <= '0;
            erased_reg    <= '0;
        end
        else
        begin
            if (!cmd_stall) begin
                item_vld_reg <= cmd_valid;
            end
            if (!res_valid_reg || !res_stall) begin
                res_valid_reg <= item_vld_reg && emit;
            end
            if (advance) begin
                busy_reg    <= busy_next;
                op_reg      <= op_next;
                step_reg    <= step_next;
                polling_reg <= polling_next;
                taddr_reg   <= taddr_next;
                tdata_reg   <= tdata_next;
                flags_reg   <= flags_next;
                erased_reg  <= erased_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall) begin
            item_reg.func             <= op_t'(func);
            item_reg.address          <= address;
            item_reg.data             <= data;
            item_reg.block_index      <= block_index;
            item_reg.big_endian_bytes <= big_endian_bytes;
            item_reg.big_endian_bits  <= big_endian_bits;
            item_reg.access_failed    <= access_failed;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res_valid            = res_valid_reg;
    assign kind                 = res_reg.kind;
    assign bus_address          = res_reg.bus_address;
    assign bus_data             = res_reg.bus_data;
    assign use_big_endian_bytes = res_reg.use_big_endian_bytes;
    assign use_big_endian_bits  = res_reg.use_big_endian_bits;
    assign success              = res_reg.success;
    assign error_code           = res_reg.error_code;
    assign read_back            = res_reg.read_back;
    assign erased_map           = res_reg.erased_map;

    a_polling_busy: assert property (@(posedge clk) disable iff (!rst_n)
        polling_reg |-> busy_reg)
        else $error("polling while idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && res_next.kind == KIND_DONE) |=> (!busy_reg && res_valid_reg))
        else $error("done without returning to idle");

    a_erased_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((erased_reg & $past(erased_reg)) == $past(erased_reg)))
        else $error("erased flag cleared");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (item_vld_reg && res_valid_reg && res_stall))
        else $error("request stalled with free result register");

endmodule
